// ===== src/btb_two_level_branch_predictor_assert.svh =====
// Assertion macros for the branch predictor.
`ifndef BTB_TWO_LEVEL_BRANCH_PREDICTOR_ASSERT_SVH
`define BTB_TWO_LEVEL_BRANCH_PREDICTOR_ASSERT_SVH
// Implication checked every clock outside reset.
`define BTB_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BTB_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== src/btb_pkg.sv =====
// Shared types and constants for the branch predictor.
package btb_pkg;
  localparam int ROWS = 256;
  localparam int ROW_BITS = 8;
  localparam logic [1:0] CTR_MAX = 2'd3;
  localparam int SHARE_HIGH_SHIFT = 16;
  localparam logic [31:0] PC_STEP = 32'd4;
  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE = 1'b1;
  localparam logic [2:0] REG_HIST = 3'd0;
  localparam logic [2:0] REG_TAG = 3'd1;
  localparam logic [2:0] REG_CINIT = 3'd2;
  localparam logic [2:0] REG_GHIST = 3'd3;
  localparam logic [2:0] REG_GTAB = 3'd4;
  localparam logic [2:0] REG_SHARE = 3'd5;
  typedef struct packed {
    logic [3:0] history_bits;
    logic [4:0] tag_bits;
    logic [1:0] counter_init;
    logic       global_history;
    logic       global_table;
    logic [1:0] share_mode;
  } cfg_t;
endpackage

// ===== src/btb_ctr_mem.sv =====
// Direction counter memory with a clearing walker for whole-memory and single-table reloads.
module btb_ctr_mem #(
  parameter int SLOT_BITS = 5,
  parameter int SLOTS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear_all,
  input  logic                  clear_tab,
  input  logic [SLOT_BITS-1:0]  clear_idx,
  input  logic [1:0]            init_val,
  input  logic [SLOT_BITS+7:0]  raddr,
  output logic [1:0]            rdata,
  input  logic                  we,
  input  logic [SLOT_BITS+7:0]  waddr,
  input  logic [1:0]            wdata,
  output logic                  busy
);
  import btb_pkg::*;
  localparam int AW = SLOT_BITS + 8;

  logic [1:0] mem [SLOTS*ROWS];
  logic          active;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] clr_last;

  // Walk one address per cycle: the whole memory after reset or a
  // configuration write, one 256-row table on a replacement.
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      active <= 1'b1;
      clr_addr <= '0;
      clr_last <= AW'(SLOTS*ROWS - 1);
    end else if (clear_tab) begin
      active <= 1'b1;
      clr_addr <= {clear_idx, 8'd0};
      clr_last <= {clear_idx, 8'hFF};
    end else if (active) begin
      if (clr_addr == clr_last) active <= 1'b0;
      else clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (active) mem[clr_addr] <= init_val;
    else if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
  assign busy = active;
endmodule

// ===== src/btb_two_level_branch_predictor.sv =====
// Top level: direct-mapped BTB with two-level direction prediction.
// An accepted transaction walks these steps: the entry step reads the BTB
// entry and history, the lookup step reads the counter memory, the finish
// step computes the result and, for an update, writes back counter, history
// and entry, and the block is then idle again. The result becomes valid as
// the finish step ends, and the next transaction can be accepted once the
// block is idle. One transaction is in flight at a time; the output register
// parts the two sides, so a new transaction can enter while a result waits,
// and it holds in its lookup step until the output register frees. An
// update that replaces a valid entry with local counter tables reloads that
// entry's 256-row table one row per cycle, waiting until it is done. After
// reset and after every write to a configuration register the whole counter
// memory (8192 rows) is reloaded with the initial counter value, one row per
// cycle, and input is held off until the reload is done.
module btb_two_level_branch_predictor #(
  parameter int BTB_ENTRIES = 32,
  parameter int MAX_HISTORY_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,  // branch_pc, resolved_target, predicted_dest
  input  logic [1:0]   s_tuser,  // operation, was_taken
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,  // predict_taken, predict_target, branch_count, flush_count
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import btb_pkg::*;
  localparam int LG = (BTB_ENTRIES >= 32) ? 5 : (BTB_ENTRIES >= 16) ? 4 :
                      (BTB_ENTRIES >= 8) ? 3 : (BTB_ENTRIES >= 4) ? 2 :
                      (BTB_ENTRIES >= 2) ? 1 : 0;
  localparam int SB = 5;
  localparam int SLOTS = 32;
  localparam logic [4:0] TAG_MAX = 5'(30 - LG);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_ENTRY  = 3'd1;
  localparam logic [2:0] PH_LOOK   = 3'd2;
  localparam logic [2:0] PH_WAIT   = 3'd3;
  localparam logic [2:0] PH_FINISH = 3'd4;

  cfg_t cfg;
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{4'd8, 5'd25, 2'd1, 1'b0, 1'b0, 2'd0};
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_HIST:  cfg.history_bits <= pwdata[3:0];
        REG_TAG:   cfg.tag_bits <= pwdata[4:0];
        REG_CINIT: cfg.counter_init <= pwdata[1:0];
        REG_GHIST: cfg.global_history <= pwdata[0];
        REG_GTAB:  cfg.global_table <= pwdata[0];
        REG_SHARE: cfg.share_mode <= pwdata[1:0];
        default: ;
      endcase
    end
  end
  logic reinit;
  assign reinit = cfg_wr && (paddr[4:2] <= REG_SHARE);
  always_comb begin
    case (paddr[4:2])
      REG_HIST:  prdata = {28'd0, cfg.history_bits};
      REG_TAG:   prdata = {27'd0, cfg.tag_bits};
      REG_CINIT: prdata = {30'd0, cfg.counter_init};
      REG_GHIST: prdata = {31'd0, cfg.global_history};
      REG_GTAB:  prdata = {31'd0, cfg.global_table};
      REG_SHARE: prdata = {30'd0, cfg.share_mode};
      default:   prdata = 32'd0;
    endcase
  end

  // Derived settings.
  logic [3:0] hlen;
  logic [7:0] hmask;
  logic [4:0] tbits;
  logic [29:0] tmask;
  assign hlen = (cfg.history_bits == 4'd0) ? 4'd1 :
                (cfg.history_bits > 4'(MAX_HISTORY_BITS)) ? 4'(MAX_HISTORY_BITS) :
                cfg.history_bits;
  assign hmask = 8'((9'd1 << hlen) - 9'd1);
  assign tbits = (cfg.tag_bits > TAG_MAX) ? TAG_MAX : cfg.tag_bits;
  assign tmask = 30'((31'd1 << tbits) - 31'd1);

  // Captured item.
  logic [2:0] phase;
  logic op, tk;
  logic [31:0] pc, tgt, pred;
  logic [31:0] ucnt, fcnt;
  logic [SB-1:0] slot;
  logic [29:0] tag;
  logic c_busy;
  logic out_free;
  assign s_tready = (phase == PH_IDLE) && !c_busy;
  // The output register is free now or frees at this edge.
  assign out_free = !m_tvalid || m_tready;
  assign slot = SB'((pc >> 2) & ((32'd1 << LG) - 32'd1));
  assign tag = 30'(pc >> (2 + LG)) & tmask;

  // Entry and history stores; valid bits cleared at once.
  logic [SLOTS-1:0] vbits;
  logic [29:0] tag_mem [SLOTS];
  logic [31:0] tgt_mem [SLOTS];
  logic [7:0]  hist_mem [SLOTS];
  logic [SLOTS-1:0] hvalid;
  logic [29:0] e_tag;
  logic [31:0] e_tgt;
  logic [7:0] e_hist;
  logic e_valid, e_hv;
  logic [SB-1:0] hslot, tslot;
  assign hslot = cfg.global_history ? '0 : slot;
  assign tslot = cfg.global_table ? '0 : slot;

  logic hit, replace, need_clr;
  logic [7:0] hcur, row;
  assign hit = e_valid && (e_tag == tag);
  assign replace = e_valid && (e_tag != tag);
  // A replacing update with local tables reloads the evicted table first.
  assign need_clr = (op == OP_UPDATE) && replace && !cfg.global_table;
  always_comb begin
    hcur = e_hv ? (e_hist & hmask) : 8'd0;
    if (op == OP_UPDATE && replace && !cfg.global_history) hcur = 8'd0;
    row = hcur;
    if (cfg.global_table) begin
      if (cfg.share_mode == 2'd1) row = hcur ^ (pc[9:2] & hmask);
      else if (cfg.share_mode == 2'd2) row = hcur ^ (pc[23:16] & hmask);
    end
  end

  logic [1:0] c_rd, c_new;
  logic [SB+7:0] caddr;
  logic c_we, clr_tab;
  assign caddr = {tslot, row};
  assign clr_tab = (phase == PH_LOOK) && need_clr;
  assign c_we = (phase == PH_FINISH) && op == OP_UPDATE;
  always_comb begin
    c_new = c_rd;
    if (tk) begin
      if (c_rd != CTR_MAX) c_new = c_rd + 2'd1;
    end else if (c_rd != 2'd0) begin
      c_new = c_rd - 2'd1;
    end
  end

  btb_ctr_mem #(.SLOT_BITS(SB), .SLOTS(SLOTS)) u_ctr (
    .clk(clk), .rst(rst), .clear_all(reinit), .clear_tab(clr_tab),
    .clear_idx(slot), .init_val(cfg.counter_init),
    .raddr(caddr), .rdata(c_rd), .we(c_we), .waddr(caddr), .wdata(c_new),
    .busy(c_busy));

  logic [31:0] fall;
  assign fall = pc + PC_STEP;
  logic mispred;
  assign mispred = (tk && tgt != pred) || (!tk && fall != pred);
  logic [31:0] ucnt_next, fcnt_next;
  assign ucnt_next = ucnt + 32'd1;
  assign fcnt_next = fcnt + 32'd1;

  // Result fields; update transactions report no prediction.
  logic res_tk;
  logic [31:0] res_tgt;
  always_comb begin
    res_tk = 1'b0;
    res_tgt = 32'd0;
    if (op == OP_PREDICT) begin
      res_tgt = fall;
      if (hit && c_rd[1]) begin
        res_tk = 1'b1;
        res_tgt = e_tgt;
      end
    end
  end

  logic out_tk;
  logic [31:0] out_tgt, out_u, out_f;

  always_ff @(posedge clk) begin
    if (phase == PH_ENTRY) begin
      e_tag <= tag_mem[slot];
      e_tgt <= tgt_mem[slot];
      e_hist <= hist_mem[hslot];
    end
    if (phase == PH_FINISH && op == OP_UPDATE) begin
      tag_mem[slot] <= tag;
      tgt_mem[slot] <= tgt;
      hist_mem[hslot] <= ((hcur << 1) | {7'd0, tk}) & hmask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || reinit) begin
      phase <= PH_IDLE;
      vbits <= '0;
      hvalid <= '0;
      ucnt <= '0;
      fcnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (phase == PH_FINISH) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (phase)
        PH_IDLE: if (s_tvalid && s_tready) begin
          op <= s_tuser[0];
          tk <= s_tuser[1];
          pc <= s_tdata[31:0];
          tgt <= s_tdata[63:32];
          pred <= s_tdata[95:64];
          phase <= PH_ENTRY;
        end
        PH_ENTRY: begin
          e_valid <= vbits[slot];
          e_hv <= hvalid[hslot];
          phase <= PH_LOOK;
        end
        PH_LOOK: begin
          if (need_clr) phase <= PH_WAIT;
          else if (out_free) phase <= PH_FINISH;
        end
        // Hold until the table reload is done and the output register is free; the counter is reread each cycle.
        PH_WAIT: if (!c_busy && out_free) phase <= PH_FINISH;
        PH_FINISH: begin
          phase <= PH_IDLE;
          out_tk <= res_tk;
          out_tgt <= res_tgt;
          if (op == OP_UPDATE) begin
            ucnt <= ucnt_next;
            out_u <= ucnt_next;
            if (mispred) begin
              fcnt <= fcnt_next;
              out_f <= fcnt_next;
            end else begin
              out_f <= fcnt;
            end
            vbits[slot] <= 1'b1;
            hvalid[hslot] <= 1'b1;
          end else begin
            out_u <= ucnt;
            out_f <= fcnt;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end
  assign m_tdata = {7'd0, out_f, out_u, out_tgt, out_tk};

`include "btb_two_level_branch_predictor_assert.svh"
  `BTB_ASSERT_IMP(a_busy_no_accept, clk, rst, phase != PH_IDLE, !s_tready)
  `BTB_ASSERT_NEXT(a_finish_valid, clk, rst, phase == PH_FINISH && !reinit, m_tvalid)
  `BTB_ASSERT_NEXT(a_upd_count, clk, rst,
    phase == PH_FINISH && op == OP_UPDATE && !reinit, ucnt == $past(ucnt) + 32'd1)
endmodule

// ===== test/btb_two_level_branch_predictor_test.sv =====
// Self-checking testbench for the two-level branch predictor with BTB.
module btb_two_level_branch_predictor_test;
  import btb_pkg::*;

  // One input transaction and one result transaction.
  typedef struct packed {
    logic        op;
    logic [31:0] pc;
    logic [31:0] tgt;
    logic        taken;
    logic [31:0] pred;
  } branch_item_t;

  typedef struct packed {
    logic        taken;
    logic [31:0] target;
    logic [31:0] branches;
    logic [31:0] flushes;
  } branch_result_t;

  localparam int SLOTS = 32;
  localparam int CYCLE_LIMIT = 2000000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [95:0]  s_tdata;  // branch_pc, resolved_target, predicted_dest
  logic [1:0]   s_tuser;  // operation, was_taken
  logic         m_tvalid;
  logic         m_tready;
  logic [103:0] m_tdata;  // predict_taken, predict_target, branch_count, flush_count
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  btb_two_level_branch_predictor dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the predictor: configuration, BTB and direction state.
  // ---------------------------------------------------------------------
  cfg_t        shadow_cfg;
  logic        btb_valid [SLOTS];
  logic [29:0] btb_tag [SLOTS];
  logic [31:0] btb_target [SLOTS];
  logic [7:0]  hist_reg [SLOTS];
  logic [1:0]  dir_ctr [SLOTS*ROWS];
  logic [31:0] branches_seen;
  logic [31:0] flushes_seen;

  branch_item_t   pending_items[$];
  branch_result_t expected_results[$];

  int unsigned errors;
  int unsigned results_checked;
  int unsigned cycle_count;
  int unsigned updates_sent;
  int unsigned predicts_sent;
  int unsigned hits_taken;

  // Reload every store from the current configuration.
  task automatic clear_shadow();
    for (int i = 0; i < SLOTS; i++) begin
      btb_valid[i] = 1'b0;
      btb_tag[i] = '0;
      btb_target[i] = '0;
      hist_reg[i] = '0;
    end
    for (int i = 0; i < SLOTS*ROWS; i++) dir_ctr[i] = shadow_cfg.counter_init;
    branches_seen = '0;
    flushes_seen = '0;
  endtask

  function automatic logic [7:0] hist_mask();
    int len;
    len = shadow_cfg.history_bits;
    if (len < 1) len = 1;
    if (len > 8) len = 8;
    return 8'((1 << len) - 1);
  endfunction

  function automatic logic [29:0] tag_of(logic [31:0] pc);
    int tb;
    logic [31:0] m;
    tb = shadow_cfg.tag_bits;
    if (tb > 25) tb = 25;  // 30 minus 5 index bits
    m = (32'h1 << tb) - 32'h1;
    return 30'((pc >> 7) & m);
  endfunction

  // Counter address: table base plus history row, optionally XORed with pc.
  function automatic int ctr_addr(logic [31:0] pc, int slot);
    int hs;
    int ts;
    logic [7:0] m;
    logic [7:0] row;
    hs = shadow_cfg.global_history ? 0 : slot;
    ts = shadow_cfg.global_table ? 0 : slot;
    m = hist_mask();
    row = hist_reg[hs] & m;
    if (shadow_cfg.global_table) begin
      if (shadow_cfg.share_mode == 2'd1) row ^= pc[9:2] & m;
      else if (shadow_cfg.share_mode == 2'd2) row ^= pc[23:16] & m;
    end
    return ts * ROWS + row;
  endfunction

  // Apply one accepted item to the shadow state and return its result.
  function automatic branch_result_t predict_branch(branch_item_t it);
    branch_result_t r;
    int slot;
    int hs;
    int at;
    logic [29:0] tg;
    logic [31:0] fall;
    slot = it.pc[6:2];
    tg = tag_of(it.pc);
    fall = it.pc + PC_STEP;
    r.taken = 1'b0;
    r.target = '0;
    if (it.op == OP_PREDICT) begin
      r.target = fall;
      if (btb_valid[slot] && btb_tag[slot] == tg && dir_ctr[ctr_addr(it.pc, slot)] >= 2'd2)
      begin
        r.taken = 1'b1;
        r.target = btb_target[slot];
      end
    end else begin
      branches_seen++;
      if ((it.taken && it.tgt != it.pred) || (!it.taken && fall != it.pred)) flushes_seen++;
      // Replacement wipes the evicted entry's local state.
      if (btb_valid[slot] && btb_tag[slot] != tg) begin
        if (!shadow_cfg.global_table)
          for (int i = 0; i < ROWS; i++) dir_ctr[slot*ROWS + i] = shadow_cfg.counter_init;
        if (!shadow_cfg.global_history) hist_reg[slot] = '0;
      end
      btb_valid[slot] = 1'b1;
      btb_tag[slot] = tg;
      btb_target[slot] = it.tgt;
      // Train the counter first, then shift the outcome into history.
      hs = shadow_cfg.global_history ? 0 : slot;
      at = ctr_addr(it.pc, slot);
      if (it.taken) begin
        if (dir_ctr[at] != CTR_MAX) dir_ctr[at]++;
      end else begin
        if (dir_ctr[at] != 2'd0) dir_ctr[at]--;
      end
      hist_reg[hs] = {hist_reg[hs][6:0], it.taken} & hist_mask();
    end
    r.branches = branches_seen;
    r.flushes = flushes_seen;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: feed pending items onto the slave stream with random gaps.
  // ---------------------------------------------------------------------
  logic         send_idle;
  int unsigned  send_gap;
  branch_item_t cur_item;
  logic         next_valid;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_branch(cur_item));
        if (cur_item.op == OP_UPDATE) updates_sent++;
        else predicts_sent++;
        next_valid = 1'b0;
        send_gap = send_idle ? $urandom_range(0, 7) : 0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          s_tdata <= {cur_item.pred, cur_item.tgt, cur_item.pc};
          s_tuser <= {cur_item.taken, cur_item.op};
          next_valid = 1'b1;
        end
      end
      s_tvalid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: accept results with random stalls and check each field.
  // ---------------------------------------------------------------------
  logic           recv_idle;
  int unsigned    recv_wait;
  int unsigned    hold_cycles;
  logic           hold_req;
  logic           hold_done;
  branch_result_t exp_r;
  branch_result_t got_r;

  // Long receiver hold-off, counted here so the sender keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_cycles <= 300;
      hold_done <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_r.taken = m_tdata[0];
        got_r.target = m_tdata[32:1];
        got_r.branches = m_tdata[64:33];
        got_r.flushes = m_tdata[96:65];
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected result %h", m_tdata);
        end else begin
          exp_r = expected_results.pop_front();
          results_checked++;
          if (exp_r.taken && got_r.taken) hits_taken++;
          if (got_r != exp_r) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: result %0d exp %b/%h/%0d/%0d got %b/%h/%0d/%0d",
                       results_checked, exp_r.taken, exp_r.target, exp_r.branches,
                       exp_r.flushes, got_r.taken, got_r.target, got_r.branches,
                       got_r.flushes);
          end
        end
        recv_wait = recv_idle ? $urandom_range(0, 7) : 0;
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      m_tready <= (recv_wait == 0) && (hold_cycles == 0);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  logic [31:0] pc_pool [40];

  // Two-phase register write; the shadow reinitializes at the access edge.
  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_HIST:  shadow_cfg.history_bits = val[3:0];
      REG_TAG:   shadow_cfg.tag_bits = val[4:0];
      REG_CINIT: shadow_cfg.counter_init = val[1:0];
      REG_GHIST: shadow_cfg.global_history = val[0];
      REG_GTAB:  shadow_cfg.global_table = val[0];
      REG_SHARE: shadow_cfg.share_mode = val[1:0];
      default: ;
    endcase
    clear_shadow();
  endtask

  task automatic push_item(logic op, logic [31:0] pc, logic [31:0] tgt, logic taken,
                           logic [31:0] pred);
    branch_item_t it;
    it.op = op;
    it.pc = pc;
    it.tgt = tgt;
    it.taken = taken;
    it.pred = pred;
    pending_items.push_back(it);
  endtask

  // Wait for the block to drain, then cover its pipeline depth.
  task automatic drain();
    while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random items mostly reuse a small pool of branches so entries hit,
  // train and get replaced; the rest are arbitrary addresses.
  task automatic random_items(int n);
    logic [31:0] pc;
    logic [31:0] tgt;
    logic        taken;
    logic [31:0] pred;
    for (int i = 0; i < 40; i++)
      pc_pool[i] = {$urandom_range(0, 2) == 0 ? 7'($urandom()) : 7'h0, 25'h0}
                   | {7'h0, 18'($urandom_range(0, 2)) << 10, 5'($urandom()), 2'($urandom())};
    for (int i = 0; i < n; i++) begin
      pc = ($urandom_range(0, 9) < 8) ? pc_pool[$urandom_range(0, 39)] : $urandom();
      tgt = $urandom();
      taken = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 2))
        0: pred = taken ? tgt : pc + PC_STEP;
        1: pred = taken ? pc + PC_STEP : tgt;
        default: pred = $urandom();
      endcase
      push_item($urandom_range(0, 1) ? OP_UPDATE : OP_PREDICT, pc, tgt, taken, pred);
    end
  endtask

  initial begin
    logic [3:0] p_hist [6]  = '{4'd0, 4'd15, 4'd1, 4'd4, 4'd8, 4'd3};
    logic [4:0] p_tag [6]   = '{5'd0, 5'd31, 5'd3, 5'd30, 5'd2, 5'd25};
    logic [1:0] p_cinit [6] = '{2'd0, 2'd3, 2'd2, 2'd1, 2'd3, 2'd0};
    logic       p_gh [6]    = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    logic       p_gt [6]    = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
    logic [1:0] p_share [6] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd0, 2'd1};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_req = 1'b0;
    errors = 0;
    results_checked = 0;
    cycle_count = 0;
    updates_sent = 0;
    predicts_sent = 0;
    hits_taken = 0;
    shadow_cfg = '{history_bits: 4'd8, tag_bits: 5'd25, counter_init: 2'd1,
                   global_history: 1'b0, global_table: 1'b0, share_mode: 2'd0};
    clear_shadow();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty lookup, allocate, hit on strong counter, weak miss,
    // replacement, mispredict both ways, address extremes, pc+4 wrap.
    push_item(OP_PREDICT, 32'h0000_1000, 32'h0, 1'b0, 32'h0);
    push_item(OP_UPDATE,  32'h0000_1000, 32'h0000_2000, 1'b1, 32'h0000_2000);
    push_item(OP_PREDICT, 32'h0000_1000, 32'h0, 1'b0, 32'h0);
    push_item(OP_UPDATE,  32'h0000_1000, 32'h0000_2000, 1'b1, 32'h0000_1004);
    push_item(OP_PREDICT, 32'h0000_1000, 32'h0, 1'b0, 32'h0);
    push_item(OP_UPDATE,  32'h0000_1000, 32'h0000_2000, 1'b0, 32'h0000_1004);
    push_item(OP_UPDATE,  32'h0000_1000, 32'h0000_2000, 1'b0, 32'h0000_2000);
    push_item(OP_PREDICT, 32'h0000_1000, 32'h0, 1'b0, 32'h0);
    push_item(OP_UPDATE,  32'h8000_1000, 32'hFFFF_FFFF, 1'b1, 32'h0);
    push_item(OP_PREDICT, 32'h0000_1000, 32'h0, 1'b0, 32'h0);
    push_item(OP_PREDICT, 32'h8000_1000, 32'h0, 1'b0, 32'h0);
    push_item(OP_UPDATE,  32'h8000_1000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    push_item(OP_PREDICT, 32'h8000_1000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    push_item(OP_UPDATE,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000);
    push_item(OP_UPDATE,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000);
    push_item(OP_PREDICT, 32'h0000_0000, 32'h0, 1'b0, 32'h0);
    push_item(OP_UPDATE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    push_item(OP_UPDATE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0003);
    push_item(OP_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    push_item(OP_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0);
    drain();

    // Default configuration with idling on both sides and one long hold.
    send_idle <= 1'b1;
    recv_idle <= 1'b1;
    hold_req <= 1'b1;
    random_items(150);
    drain();

    // Sweep the register settings; every register is written each phase.
    for (int p = 0; p < 6; p++) begin
      cfg_write(REG_HIST,  {28'h0, p_hist[p]});
      cfg_write(REG_TAG,   {27'h0, p_tag[p]});
      cfg_write(REG_CINIT, {30'h0, p_cinit[p]});
      cfg_write(REG_GHIST, {31'h0, p_gh[p]});
      cfg_write(REG_GTAB,  {31'h0, p_gt[p]});
      cfg_write(REG_SHARE, {30'h0, p_share[p]});
      // Alternate stretches with and without idling.
      send_idle <= p[0];
      recv_idle <= (p % 3) != 0;
      random_items(210);
      drain();
    end

    $display("Covered %0d predict and %0d update transactions over 7 register settings,",
             predicts_sent, updates_sent);
    $display("%0d results checked, %0d taken hits predicted.", results_checked, hits_taken);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
